// ===== hdl/estc_pkg.sv =====
// shared constants and types for the edge stream tree checker
`default_nettype none
package estc_pkg;
    localparam int MAX_NODES = 256;
    localparam int ID_BITS   = 16;
    localparam int IDX_W     = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int CASE_W    = 16;

    typedef enum logic [1:0] {
        OP_NOP    = 2'd0,
        OP_SEARCH = 2'd1,
        OP_UPDATE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_kind_t;

    typedef struct packed {
        op_kind_t             kind;
        logic [ID_BITS-1:0]   pid;
        logic [ID_BITS-1:0]   cid;
        logic                 p_found;
        logic [IDX_W-1:0]     p_idx;
        logic [IDX_W-1:0]     p_root;
        logic                 c_found;
        logic [IDX_W-1:0]     c_idx;
        logic [IDX_W-1:0]     c_root;
        logic                 c_has;
        logic                 add_p;
        logic                 add_c;
        logic                 link;
    } op_t;
endpackage
`default_nettype wire

// ===== hdl/edge_stream_tree_checker.sv =====
// top level: sequencer and chain of node cells
//
// channel | direction | fields
// s_      | in        | s_action, s_parent_id, s_child_id
// m_      | out       | m_case_number, m_is_tree
//
// an edge transaction takes two passes down the MAX_NODES cell chain (search, then
// update); ignored edges send no pass into the chain
// end of case emits the result and runs a clear pass down the cell chain
// reset is synchronous active low; all cells come up empty
// s_ready drops while a pass is in the chain or a result waits without m_ready
`default_nettype none
module edge_stream_tree_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_action,
    input  logic [15:0]                 s_parent_id,
    input  logic [15:0]                 s_child_id,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [estc_pkg::CASE_W-1:0] m_case_number,
    output logic                        m_is_tree
);
    import estc_pkg::*;

    op_t links [MAX_NODES+1];

    estc_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_parent_id   (s_parent_id),
        .s_child_id    (s_child_id),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_case_number (m_case_number),
        .m_is_tree     (m_is_tree),
        .chain_in      (links[0]),
        .chain_out     (links[MAX_NODES])
    );

    for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
        estc_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (IDX_W'(i)),
            .op_in    (links[i]),
            .op_out   (links[i+1])
        );
    end
endmodule
`default_nettype wire

// ===== hdl/estc_cell.sv =====
// one node table entry; acts on the operation passing through and hands it on
`default_nettype none
module estc_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [estc_pkg::IDX_W-1:0] cell_idx,
    input  estc_pkg::op_t          op_in,
    output estc_pkg::op_t          op_out
);
    import estc_pkg::*;

    logic                 valid_reg, valid_next;
    logic [ID_BITS-1:0]   id_reg, id_next;
    logic [IDX_W-1:0]     root_reg, root_next;
    logic                 has_reg, has_next;
    op_t                  op_reg, op_next;

    always_comb begin
        op_next    = op_in;
        valid_next = valid_reg;
        id_next    = id_reg;
        root_next  = root_reg;
        has_next   = has_reg;
        unique case (op_in.kind)
            OP_SEARCH: begin
                if (valid_reg && id_reg == op_in.pid) begin
                    op_next.p_found = 1'b1;
                    op_next.p_idx   = cell_idx;
                    op_next.p_root  = root_reg;
                end
                if (valid_reg && id_reg == op_in.cid) begin
                    op_next.c_found = 1'b1;
                    op_next.c_idx   = cell_idx;
                    op_next.c_root  = root_reg;
                    op_next.c_has   = has_reg;
                end
            end
            OP_UPDATE: begin
                if (op_in.add_p && cell_idx == op_in.p_idx) begin
                    valid_next = 1'b1;
                    id_next    = op_in.pid;
                    has_next   = 1'b0;
                    root_next  = op_in.p_idx;
                end else if (op_in.add_c && cell_idx == op_in.c_idx) begin
                    valid_next = 1'b1;
                    id_next    = op_in.cid;
                    has_next   = op_in.link;
                    root_next  = op_in.link ? op_in.p_root : op_in.c_idx;
                end else if (valid_reg && op_in.link) begin
                    if (root_reg == op_in.c_idx) begin
                        root_next = op_in.p_root;
                    end
                    if (cell_idx == op_in.c_idx) begin
                        has_next = 1'b1;
                    end
                end
            end
            OP_CLEAR: begin
                valid_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            op_reg.kind <= OP_NOP;
        end else begin
            valid_reg   <= valid_next;
            op_reg.kind <= op_next.kind;
        end
        id_reg   <= id_next;
        root_reg <= root_next;
        has_reg  <= has_next;
        op_reg.pid     <= op_next.pid;
        op_reg.cid     <= op_next.cid;
        op_reg.p_found <= op_next.p_found;
        op_reg.p_idx   <= op_next.p_idx;
        op_reg.p_root  <= op_next.p_root;
        op_reg.c_found <= op_next.c_found;
        op_reg.c_idx   <= op_next.c_idx;
        op_reg.c_root  <= op_next.c_root;
        op_reg.c_has   <= op_next.c_has;
        op_reg.add_p   <= op_next.add_p;
        op_reg.add_c   <= op_next.add_c;
        op_reg.link    <= op_next.link;
    end

    assign op_out = op_reg;
endmodule
`default_nettype wire

// ===== hdl/estc_ctrl.sv =====
// sequencer: takes transactions, issues operations into the cell chain, keeps counts
`default_nettype none
module estc_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_action,
    input  logic [15:0]                 s_parent_id,
    input  logic [15:0]                 s_child_id,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [estc_pkg::CASE_W-1:0] m_case_number,
    output logic                        m_is_tree,
    output estc_pkg::op_t               chain_in,
    input  estc_pkg::op_t               chain_out
);
    import estc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WAIT = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    node_count_reg, node_count_next;
    logic [CNT_W-1:0]    root_count_reg, root_count_next;
    logic                tree_valid_reg, tree_valid_next;
    logic [CASE_W-1:0]   case_reg, case_next;
    logic                m_valid_reg, m_valid_next;
    logic [CASE_W-1:0]   m_case_reg, m_case_next;
    logic                m_tree_reg, m_tree_next;

    logic [ID_BITS-1:0]  pid, cid;
    logic                p_new, c_new, add_p, add_c, link;
    logic [IDX_W-1:0]    pi, pr, ci;
    logic [CNT_W-1:0]    cnt1;
    logic                chas;

    assign pid = s_parent_id[ID_BITS-1:0];
    assign cid = s_child_id[ID_BITS-1:0];

    assign p_new = !chain_out.p_found;
    assign c_new = !chain_out.c_found;
    assign pi    = chain_out.p_found ? chain_out.p_idx : node_count_reg[IDX_W-1:0];
    assign pr    = chain_out.p_found ? chain_out.p_root : pi;
    assign cnt1  = node_count_reg + CNT_W'(p_new);
    assign ci    = chain_out.c_found ? chain_out.c_idx : cnt1[IDX_W-1:0];
    assign chas  = chain_out.c_found ? chain_out.c_has : 1'b0;

    always_comb begin
        add_p = 1'b0;
        add_c = 1'b0;
        link  = 1'b0;
        priority if (p_new && node_count_reg == CNT_W'(MAX_NODES)) begin
        end else if (chain_out.cid == chain_out.pid) begin
            add_p = p_new;
        end else if (c_new && cnt1 == CNT_W'(MAX_NODES)) begin
            add_p = p_new;
        end else begin
            add_p = p_new;
            add_c = c_new;
            link  = !(chas || pr == ci);
        end
    end

    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next      = state_reg;
        node_count_next = node_count_reg;
        root_count_next = root_count_reg;
        tree_valid_next = tree_valid_reg;
        case_next       = case_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_case_next     = m_case_reg;
        m_tree_next     = m_tree_reg;
        chain_in        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    if (s_action) begin
                        m_valid_next    = 1'b1;
                        m_case_next     = case_reg;
                        m_tree_next     = tree_valid_reg && (root_count_reg < CNT_W'(2));
                        case_next       = (case_reg == {CASE_W{1'b1}}) ? CASE_W'(1)
                                                                       : case_reg + CASE_W'(1);
                        node_count_next = '0;
                        root_count_next = '0;
                        tree_valid_next = 1'b1;
                        chain_in.kind   = OP_CLEAR;
                        state_next      = S_WAIT;
                    end else if (tree_valid_reg && pid != '0 && cid != '0) begin
                        chain_in.kind = OP_SEARCH;
                        chain_in.pid  = pid;
                        chain_in.cid  = cid;
                        state_next    = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                if (chain_out.kind == OP_SEARCH) begin
                    chain_in.kind   = OP_UPDATE;
                    chain_in.pid    = chain_out.pid;
                    chain_in.cid    = chain_out.cid;
                    chain_in.p_idx  = pi;
                    chain_in.p_root = pr;
                    chain_in.c_idx  = ci;
                    chain_in.add_p  = add_p;
                    chain_in.add_c  = add_c;
                    chain_in.link   = link;
                    node_count_next = node_count_reg + CNT_W'(add_p) + CNT_W'(add_c);
                    root_count_next = root_count_reg + CNT_W'(add_p) + CNT_W'(add_c)
                                      - CNT_W'(link);
                    if (!link) begin
                        tree_valid_next = 1'b0;
                    end
                end else if (chain_out.kind != OP_NOP) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            node_count_reg <= '0;
            root_count_reg <= '0;
            tree_valid_reg <= 1'b1;
            case_reg       <= CASE_W'(1);
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            root_count_reg <= root_count_next;
            tree_valid_reg <= tree_valid_next;
            case_reg       <= case_next;
            m_valid_reg    <= m_valid_next;
        end
        m_case_reg <= m_case_next;
        m_tree_reg <= m_tree_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_case_number = m_case_reg;
    assign m_is_tree     = m_tree_reg;
endmodule
`default_nettype wire

// ===== hdl/estc_checker.sv =====
// port level assertions for the edge stream tree checker and their bind
`default_nettype none
module estc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_action,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_case_number,
    input logic        m_is_tree
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_case_number) && $stable(m_is_tree))
        else $error("result changed while stalled");

    a_case_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_case_number != 16'd0)
        else $error("case number zero");

    a_end_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_action |=> m_valid)
        else $error("end of case without result");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready && m_valid |-> m_ready)
        else $error("input taken while result blocked");
endmodule

bind edge_stream_tree_checker estc_checker u_estc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_action      (s_action),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_case_number (m_case_number),
    .m_is_tree     (m_is_tree)
);
`default_nettype wire
